// File: src/psp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Photodiode steering package
// Shared types, register indexes and constants of the steering controller.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int NUM_CH    = 7;
  localparam int CH_IDX_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W    = 16;
  localparam int DRIVE_W   = 16;
  localparam int LEVEL_W   = 10;
  localparam int ERR_SUM_W = 32;
  localparam int DIV3_W    = 18;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_MARGIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PUCK_THRESHOLD = 3'd6;

  localparam logic [GAIN_W-1:0]  KP_RESET        = 16'd26;
  localparam logic [GAIN_W-1:0]  KI_RESET        = 16'd0;
  localparam logic [GAIN_W-1:0]  KD_RESET        = 16'd0;
  localparam logic [DRIVE_W-1:0] MAX_SPEED_RESET = 16'd255;
  localparam logic [DRIVE_W-1:0] MIN_SPEED_RESET = 16'd50;
  localparam logic [LEVEL_W-1:0] MARGIN_RESET    = 10'd50;
  localparam logic [LEVEL_W-1:0] PUCK_RESET      = 10'd300;

  // ceil(2^20 / 3); exact floor division by three for inputs below 2^18.
  localparam logic [18:0] DIV3_RECIP = 19'd349526;

  typedef enum logic [1:0] {
    MODE_STRAIGHT = 2'd0,
    MODE_LEFT     = 2'd1,
    MODE_RIGHT    = 2'd2
  } steer_mode_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [DRIVE_W-1:0] max_speed;
    logic [DRIVE_W-1:0] min_speed;
    logic [LEVEL_W-1:0] turn_margin;
    logic [LEVEL_W-1:0] puck_threshold;
  } cfg_t;

  typedef struct packed {
    steer_mode_t mode;
    logic        do_pid;
    logic        puck;
  } steer_ctrl_t;

  function automatic logic [DIV3_W-1:0] div3(input logic [DIV3_W-1:0] x);
    logic [DIV3_W+19:0] prod;
    prod = {20'd0, x} * {{(DIV3_W+1){1'b0}}, DIV3_RECIP};
    return prod[DIV3_W+19:20];
  endfunction

endpackage
`default_nettype wire

// File: src/psp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Steering controller channels
// Valid/ready channels for request words, result words and register writes.
// ----------------------------------------------------------------------------
interface psp_req_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface psp_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [psp_pkg::DRIVE_W-1:0]    left_drive;
  logic [psp_pkg::DRIVE_W-1:0]    right_drive;
  logic [1:0]                     steer_mode;
  logic                           pid_applied;
  logic                           puck_held;

  modport source (output valid, output left_drive, output right_drive, output steer_mode,
                  output pid_applied, output puck_held, input ready);
  modport sink   (input valid, input left_drive, input right_drive, input steer_mode,
                  input pid_applied, input puck_held, output ready);
endinterface

interface psp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [psp_pkg::CFG_IDX_W-1:0]   index;
  logic [psp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/photodiode_array_steering_pid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Photodiode array steering controller with PID correction
// Stores photodiode samples and turns steering ticks into motor drive levels.
// ----------------------------------------------------------------------------
// Usage. Request words arrive on req: a sample word (req_type low) writes the
// reading into the next of seven channels and produces no result; a steer tick
// (req_type high) produces exactly one result word on rsp carrying both drive
// levels, the steering mode, whether the PID correction was applied, and the
// puck flag. Registers are written on cfg, one word per cycle; the user must
// write them only while no work is outstanding, which the block itself does
// not enforce; writes beyond the register list are ignored. A tick taken with
// the snapshot then passes the decision, gain product and result registers.
// Throughput: one request word per cycle while the result channel keeps up. The
// integral and last error are updated, when the PID correction is applied, as a
// tick leaves the decision stage, so back-to-back ticks are handled at full rate.
// Stall: each stage holds while the stage after it is full and blocked, so
// req.ready only falls once the pipeline has filled behind an untaken result;
// bubbles left by sample words are squeezed out.
// Reset (rst, synchronous) clears the sample store, channel index, PID state,
// pipeline valid flags and returns the registers to their reset values.
// ----------------------------------------------------------------------------
module photodiode_array_steering_pid #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic clk,
  input  wire logic rst,
  psp_req_if.sink   req,
  psp_rsp_if.source rsp,
  psp_cfg_if.sink   cfg
);

  localparam int EW = SAMPLE_BITS + 2;

  psp_pkg::cfg_t regs;

  // Pipeline valid flags and per-stage load enables.
  logic v1, v2, v3, v4;
  logic ld1, ld2, ld3, ld4;
  logic req_acc;

  assign ld4 = !v4 || rsp.ready;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;

  assign req.ready = ld1;
  assign req_acc   = req.valid && ld1;

  psp_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Sample words write the store as they are accepted.
  logic [psp_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] sensors;

  psp_sensor_store #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (req_acc && !req.req_type),
    .wr_data (req.sample),
    .sensors (sensors)
  );

  // Stage 1: a tick takes a snapshot of the store so later samples cannot
  // disturb it.
  logic [psp_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= req_acc && req.req_type;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      snap <= sensors;
    end
  end

  // Stage 1 to 2: turn decision, error terms and the integral update.
  psp_pkg::steer_ctrl_t               ctrl1, ctrl2;
  logic [psp_pkg::DRIVE_W-1:0]        left_b1, right_b1, left_b2, right_b2;
  logic signed [EW-1:0]               err1, err2;
  logic signed [psp_pkg::ERR_SUM_W-1:0] sum1, sum2;
  logic signed [EW:0]                 diff1, diff2;

  psp_steer #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_steer (
    .clk        (clk),
    .rst        (rst),
    .upd_en     (v1 && ld2),
    .sensors    (snap),
    .regs       (regs),
    .ctrl       (ctrl1),
    .left_base  (left_b1),
    .right_base (right_b1),
    .err        (err1),
    .err_sum    (sum1),
    .err_diff   (diff1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      ctrl2    <= ctrl1;
      left_b2  <= left_b1;
      right_b2 <= right_b1;
      err2     <= err1;
      sum2     <= sum1;
      diff2    <= diff1;
    end
  end

  // Stage 3 holds the gain products inside the PID unit.
  psp_pkg::steer_ctrl_t        ctrl3;
  logic [psp_pkg::DRIVE_W-1:0] left_d3, right_d3;

  psp_pid #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_pid (
    .clk           (clk),
    .load          (ld3),
    .regs          (regs),
    .ctrl_in       (ctrl2),
    .left_base_in  (left_b2),
    .right_base_in (right_b2),
    .err           (err2),
    .err_sum       (sum2),
    .err_diff      (diff2),
    .ctrl          (ctrl3),
    .left_drive    (left_d3),
    .right_drive   (right_d3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= v2;
    end
  end

  // Stage 4: result register driving the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ld4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      rsp.left_drive  <= left_d3;
      rsp.right_drive <= right_d3;
      rsp.steer_mode  <= ctrl3.mode;
      rsp.pid_applied <= ctrl3.do_pid;
      rsp.puck_held   <= ctrl3.puck;
    end
  end

  assign rsp.valid = v4;

endmodule
`default_nettype wire

// File: src/psp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Steering controller register file
// Holds the gains, speed levels and thresholds written over the register port.
// ----------------------------------------------------------------------------
module psp_cfg_regs (
  input  wire logic    clk,
  input  wire logic    rst,
  psp_cfg_if.sink      cfg,
  output psp_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.kp_gain        <= psp_pkg::KP_RESET;
      regs.ki_gain        <= psp_pkg::KI_RESET;
      regs.kd_gain        <= psp_pkg::KD_RESET;
      regs.max_speed      <= psp_pkg::MAX_SPEED_RESET;
      regs.min_speed      <= psp_pkg::MIN_SPEED_RESET;
      regs.turn_margin    <= psp_pkg::MARGIN_RESET;
      regs.puck_threshold <= psp_pkg::PUCK_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        psp_pkg::REG_KP_GAIN:        regs.kp_gain        <= cfg.data;
        psp_pkg::REG_KI_GAIN:        regs.ki_gain        <= cfg.data;
        psp_pkg::REG_KD_GAIN:        regs.kd_gain        <= cfg.data;
        psp_pkg::REG_MAX_SPEED:      regs.max_speed      <= cfg.data;
        psp_pkg::REG_MIN_SPEED:      regs.min_speed      <= cfg.data;
        psp_pkg::REG_TURN_MARGIN:    regs.turn_margin    <= cfg.data[psp_pkg::LEVEL_W-1:0];
        psp_pkg::REG_PUCK_THRESHOLD: regs.puck_threshold <= cfg.data[psp_pkg::LEVEL_W-1:0];
        default: ; // Writes beyond the register list are dropped.
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/psp_sensor_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Photodiode sample store
// Seven readings written at a rotating channel index that wraps after six.
// ----------------------------------------------------------------------------
module psp_sensor_store #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         wr_en,
  input  wire logic [SAMPLE_BITS-1:0]                       wr_data,
  output      logic [psp_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] sensors
);

  localparam logic [psp_pkg::CH_IDX_W-1:0] LastCh = psp_pkg::CH_IDX_W'(psp_pkg::NUM_CH - 1);

  logic [psp_pkg::CH_IDX_W-1:0] channel_index;
  logic [psp_pkg::CH_IDX_W-1:0] wr_idx;

  // An out-of-range index is treated as the last channel.
  assign wr_idx = (channel_index >= LastCh) ? LastCh : channel_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= '0;
      sensors       <= '0;
    end else if (wr_en) begin
      channel_index <= (wr_idx == LastCh) ? '0 : wr_idx + 1'b1;
      for (int k = 0; k < psp_pkg::NUM_CH; k++) begin
        if (wr_idx == psp_pkg::CH_IDX_W'(k)) begin
          sensors[k] <= wr_data;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/psp_steer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Steering decision and PID error tracking
// Picks the turn from the sensor means and updates the integral and last error.
// ----------------------------------------------------------------------------
module psp_steer #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         upd_en,
  input  wire logic [psp_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] sensors,
  input  wire psp_pkg::cfg_t                                regs,
  output      psp_pkg::steer_ctrl_t                         ctrl,
  output      logic [psp_pkg::DRIVE_W-1:0]                  left_base,
  output      logic [psp_pkg::DRIVE_W-1:0]                  right_base,
  output      logic signed [SAMPLE_BITS+1:0]                err,
  output      logic signed [psp_pkg::ERR_SUM_W-1:0]         err_sum,
  output      logic signed [SAMPLE_BITS+2:0]                err_diff
);

  localparam int EW = SAMPLE_BITS + 2;
  localparam int MW = ((SAMPLE_BITS > psp_pkg::LEVEL_W) ? SAMPLE_BITS : psp_pkg::LEVEL_W) + 1;
  localparam int SW = psp_pkg::ERR_SUM_W;

  logic signed [SW-1:0]    error_sum;
  logic signed [EW-1:0]    last_error;
  logic [SAMPLE_BITS+1:0]  sum024, sum135;
  logic [psp_pkg::DIV3_W-1:0] q024, q135;
  logic [SAMPLE_BITS-1:0]  m024, m135;
  logic [MW-1:0]           m024_x, m135_x, margin_x;
  logic                    turn_left, turn_right;
  logic [SAMPLE_BITS:0]    a02, a13;
  logic signed [SW:0]      sum_wide;

  assign sum024 = (SAMPLE_BITS+2)'(sensors[0]) + (SAMPLE_BITS+2)'(sensors[2])
                + (SAMPLE_BITS+2)'(sensors[4]);
  assign sum135 = (SAMPLE_BITS+2)'(sensors[1]) + (SAMPLE_BITS+2)'(sensors[3])
                + (SAMPLE_BITS+2)'(sensors[5]);
  assign q024 = psp_pkg::div3(psp_pkg::DIV3_W'(sum024));
  assign q135 = psp_pkg::div3(psp_pkg::DIV3_W'(sum135));
  assign m024 = q024[SAMPLE_BITS-1:0];
  assign m135 = q135[SAMPLE_BITS-1:0];

  assign m024_x   = MW'(m024);
  assign m135_x   = MW'(m135);
  assign margin_x = MW'(regs.turn_margin);

  // A mean difference above the margin, or a small lead backed by the outer sensor.
  assign turn_left  = (m024_x > m135_x + margin_x) ||
                      ((m024 > m135) && (sensors[4] > sensors[2]));
  assign turn_right = (m135_x > m024_x + margin_x) ||
                      ((m135 > m024) && (sensors[5] > sensors[3]));

  always_comb begin
    ctrl.puck = (MW'(sensors[6]) > MW'(regs.puck_threshold));
    priority if (turn_left) begin
      ctrl.mode   = psp_pkg::MODE_LEFT;
      ctrl.do_pid = sensors[2] > sensors[4];
      left_base   = regs.min_speed;
      right_base  = regs.max_speed;
    end else if (turn_right) begin
      ctrl.mode   = psp_pkg::MODE_RIGHT;
      ctrl.do_pid = sensors[3] > sensors[5];
      left_base   = regs.max_speed;
      right_base  = regs.min_speed;
    end else begin
      ctrl.mode   = psp_pkg::MODE_STRAIGHT;
      ctrl.do_pid = 1'b0;
      left_base   = regs.max_speed;
      right_base  = regs.max_speed;
    end
  end

  assign a02 = (SAMPLE_BITS+1)'(sensors[0]) + (SAMPLE_BITS+1)'(sensors[2]);
  assign a13 = (SAMPLE_BITS+1)'(sensors[1]) + (SAMPLE_BITS+1)'(sensors[3]);
  assign err = $signed({1'b0, a02}) - $signed({1'b0, a13});
  assign err_diff = $signed({err[EW-1], err}) - $signed({last_error[EW-1], last_error});

  // Integral with saturation to the signed 32-bit range.
  assign sum_wide = $signed({error_sum[SW-1], error_sum})
                  + $signed({{(SW+1-EW){err[EW-1]}}, err});
  always_comb begin
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      err_sum = sum_wide[SW] ? $signed({1'b1, {(SW-1){1'b0}}})
                             : $signed({1'b0, {(SW-1){1'b1}}});
    end else begin
      err_sum = sum_wide[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
    end else if (upd_en && ctrl.do_pid) begin
      error_sum  <= err_sum;
      last_error <= err;
    end
  end

endmodule
`default_nettype wire

// File: src/psp_pid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID correction
// Registers the three gain products, then scales and applies the correction.
// ----------------------------------------------------------------------------
module psp_pid #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 load,
  input  wire psp_pkg::cfg_t                        regs,
  input  wire psp_pkg::steer_ctrl_t                 ctrl_in,
  input  wire logic [psp_pkg::DRIVE_W-1:0]          left_base_in,
  input  wire logic [psp_pkg::DRIVE_W-1:0]          right_base_in,
  input  wire logic signed [SAMPLE_BITS+1:0]        err,
  input  wire logic signed [psp_pkg::ERR_SUM_W-1:0] err_sum,
  input  wire logic signed [SAMPLE_BITS+2:0]        err_diff,
  output      psp_pkg::steer_ctrl_t                 ctrl,
  output      logic [psp_pkg::DRIVE_W-1:0]          left_drive,
  output      logic [psp_pkg::DRIVE_W-1:0]          right_drive
);

  localparam int EW = SAMPLE_BITS + 2;
  localparam int GW = psp_pkg::GAIN_W;
  localparam int DW = psp_pkg::DRIVE_W;
  localparam int RW = GW + psp_pkg::ERR_SUM_W + 2;
  localparam int UW = RW - 8;

  logic signed [GW+EW-1:0]                 p_kp;
  logic signed [GW+psp_pkg::ERR_SUM_W-1:0] p_ki;
  logic signed [GW+EW:0]                   p_kd;
  logic [DW-1:0]                           left_base, right_base;
  logic signed [RW-1:0]                    raw, adj;
  logic [RW-1:0]                           bias;
  logic signed [UW-1:0]                    u;
  logic [UW-1:0]                           mag;
  logic signed [DW:0]                      span;
  logic                                    u_pos;
  logic [DW-1:0]                           reduced;

  always_ff @(posedge clk) begin
    if (load) begin
      p_kp       <= $signed(regs.kp_gain) * err;
      p_ki       <= $signed(regs.ki_gain) * err_sum;
      p_kd       <= $signed(regs.kd_gain) * err_diff;
      ctrl       <= ctrl_in;
      left_base  <= left_base_in;
      right_base <= right_base_in;
    end
  end

  assign raw = RW'(p_kp) + RW'(p_ki) + RW'(p_kd);

  // Divide by 256 rounding toward zero: bias negative values before the shift.
  assign bias = {{(RW-8){1'b0}}, {8{raw[RW-1]}}};
  assign adj  = raw + $signed(bias);
  assign u    = adj[RW-1:8];
  assign mag  = u[UW-1] ? UW'(-u) : UW'(u);
  assign u_pos = !u[UW-1] && (u != '0);

  // The slowed side never drops below the minimum level.
  assign span = $signed({1'b0, regs.max_speed}) - $signed({1'b0, regs.min_speed});
  assign reduced = (span[DW] || (mag > UW'(span[DW-1:0]))) ? regs.min_speed
                                                          : regs.max_speed - mag[DW-1:0];

  always_comb begin
    if (!ctrl.do_pid) begin
      left_drive  = left_base;
      right_drive = right_base;
    end else if (u_pos) begin
      left_drive  = reduced;
      right_drive = regs.max_speed;
    end else begin
      left_drive  = regs.max_speed;
      right_drive = reduced;
    end
  end

endmodule
`default_nettype wire

// File: verif/photodiode_array_steering_pid_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Photodiode steering controller testbench
// Drives sample words and steer ticks through the valid/ready channels and
// checks every result word against an independent cycle-free predictor.
// ----------------------------------------------------------------------------

localparam logic REQ_SAMPLE = 1'b0;
localparam logic REQ_TICK   = 1'b1;
// Index past the end of the register list; writes to it must be ignored.
localparam logic [psp_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

typedef struct packed {
  logic [psp_pkg::DRIVE_W-1:0] left;
  logic [psp_pkg::DRIVE_W-1:0] right;
  psp_pkg::steer_mode_t        mode;
  logic                        pid;
  logic                        puck;
} drive_word_t;

class steer_scoreboard;
  logic [psp_pkg::LEVEL_W-1:0] levels [psp_pkg::NUM_CH];
  int unsigned                 chan;
  longint                      integ;
  longint                      prev_err;
  psp_pkg::cfg_t               regs;
  drive_word_t                 pending [$];
  int unsigned                 fails;

  function new();
    foreach (levels[k]) levels[k] = '0;
    chan = 0;
    integ = 0;
    prev_err = 0;
    regs.kp_gain = psp_pkg::KP_RESET;
    regs.ki_gain = psp_pkg::KI_RESET;
    regs.kd_gain = psp_pkg::KD_RESET;
    regs.max_speed = psp_pkg::MAX_SPEED_RESET;
    regs.min_speed = psp_pkg::MIN_SPEED_RESET;
    regs.turn_margin = psp_pkg::MARGIN_RESET;
    regs.puck_threshold = psp_pkg::PUCK_RESET;
    fails = 0;
  endfunction

  function void write_reg(logic [psp_pkg::CFG_IDX_W-1:0] idx,
                          logic [psp_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      psp_pkg::REG_KP_GAIN:        regs.kp_gain = data;
      psp_pkg::REG_KI_GAIN:        regs.ki_gain = data;
      psp_pkg::REG_KD_GAIN:        regs.kd_gain = data;
      psp_pkg::REG_MAX_SPEED:      regs.max_speed = data;
      psp_pkg::REG_MIN_SPEED:      regs.min_speed = data;
      psp_pkg::REG_TURN_MARGIN:    regs.turn_margin = data[psp_pkg::LEVEL_W-1:0];
      psp_pkg::REG_PUCK_THRESHOLD: regs.puck_threshold = data[psp_pkg::LEVEL_W-1:0];
      default: ;
    endcase
  endfunction

  // Works out the drive word for one steer tick and advances the PID state.
  function drive_word_t steer_decision();
    drive_word_t w;
    longint s [psp_pkg::NUM_CH];
    longint m_even, m_odd, top, floor_lvl, margin, thresh;
    longint e, d, sum, u, mag, reduced;
    logic pid_on;
    foreach (s[k]) s[k] = levels[k];
    top = regs.max_speed;
    floor_lvl = regs.min_speed;
    margin = regs.turn_margin;
    thresh = regs.puck_threshold;
    m_even = (s[0] + s[2] + s[4]) / 3;
    m_odd = (s[1] + s[3] + s[5]) / 3;
    pid_on = 1'b0;
    if (m_even - m_odd > margin || (m_even > m_odd && s[4] > s[2])) begin
      w.mode = psp_pkg::MODE_LEFT;
      w.left = floor_lvl[psp_pkg::DRIVE_W-1:0];
      w.right = top[psp_pkg::DRIVE_W-1:0];
      pid_on = s[2] > s[4];
    end else if (m_odd - m_even > margin || (m_odd > m_even && s[5] > s[3])) begin
      w.mode = psp_pkg::MODE_RIGHT;
      w.left = top[psp_pkg::DRIVE_W-1:0];
      w.right = floor_lvl[psp_pkg::DRIVE_W-1:0];
      pid_on = s[3] > s[5];
    end else begin
      w.mode = psp_pkg::MODE_STRAIGHT;
      w.left = top[psp_pkg::DRIVE_W-1:0];
      w.right = top[psp_pkg::DRIVE_W-1:0];
    end
    if (pid_on) begin
      e = (s[0] + s[2]) - (s[1] + s[3]);
      d = e - prev_err;
      sum = integ + e;
      if (sum > longint'(32'h7FFFFFFF)) sum = longint'(32'h7FFFFFFF);
      if (sum < -longint'(32'h80000000)) sum = -longint'(32'h80000000);
      integ = sum;
      u = longint'($signed(regs.kp_gain)) * e + longint'($signed(regs.ki_gain)) * sum
        + longint'($signed(regs.kd_gain)) * d;
      u = u / 256;
      prev_err = e;
      mag = (u < 0) ? -u : u;
      reduced = (mag > top - floor_lvl) ? floor_lvl : top - mag;
      if (u > 0) begin
        w.left = reduced[psp_pkg::DRIVE_W-1:0];
        w.right = top[psp_pkg::DRIVE_W-1:0];
      end else begin
        w.left = top[psp_pkg::DRIVE_W-1:0];
        w.right = reduced[psp_pkg::DRIVE_W-1:0];
      end
    end
    w.pid = pid_on;
    w.puck = s[6] > thresh;
    return w;
  endfunction

  function void note_input(logic kind, logic [psp_pkg::LEVEL_W-1:0] value);
    if (kind == REQ_SAMPLE) begin
      levels[chan] = value;
      chan = (chan >= psp_pkg::NUM_CH - 1) ? 0 : chan + 1;
    end else begin
      pending.push_back(steer_decision());
    end
  endfunction

  function void check_result(logic [psp_pkg::DRIVE_W-1:0] left,
                             logic [psp_pkg::DRIVE_W-1:0] right,
                             logic [1:0] mode, logic pid, logic puck);
    drive_word_t want;
    if (pending.size() == 0) begin
      $error("result word with no steer tick outstanding");
      fails++;
      return;
    end
    want = pending.pop_front();
    if (left !== want.left) begin
      $error("left_drive: expected %0d, got %0d", want.left, left);
      fails++;
    end
    if (right !== want.right) begin
      $error("right_drive: expected %0d, got %0d", want.right, right);
      fails++;
    end
    if (mode !== want.mode) begin
      $error("steer_mode: expected %0d, got %0d", want.mode, mode);
      fails++;
    end
    if (pid !== want.pid) begin
      $error("pid_applied: expected %0d, got %0d", want.pid, pid);
      fails++;
    end
    if (puck !== want.puck) begin
      $error("puck_held: expected %0d, got %0d", want.puck, puck);
      fails++;
    end
  endfunction

  function void check_drained();
    if (pending.size() != 0) begin
      $error("%0d result words never arrived", pending.size());
      fails++;
    end
  endfunction
endclass

module photodiode_array_steering_pid_test;

  localparam int SAMPLE_BITS    = 10;
  localparam int LW             = psp_pkg::LEVEL_W;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int NUM_PHASES     = 6;
  // The pressure phase starts with the receiver holding off for this long.
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 300;
  // Settling allowance after the last result word, before registers change.
  localparam int SETTLE_CYCLES  = 10;
  localparam int DRAIN_LIMIT    = 50000;

  // Directed frames, channel 0 in the lowest slice.
  // Alternating extremes; also proves the index wraps from 6 back to 0.
  localparam logic [7*LW-1:0] FRAME_WRAP =
    {10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023};
  // Left turn whose inner sensor beats the outer one, so PID takes over;
  // the front sensor sits exactly on the threshold and must not count.
  localparam logic [7*LW-1:0] FRAME_LEFT_PID =
    {10'd300, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd0, 10'd0};
  // Mirror case to the right with the front sensor one above the threshold.
  localparam logic [7*LW-1:0] FRAME_RIGHT_PID =
    {10'd301, 10'd0, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd0};

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   phase;

  steer_scoreboard sb = new();

  psp_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
  psp_rsp_if rsp_ch ();
  psp_cfg_if cfg_ch ();

  photodiode_array_steering_pid #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // The receiver takes result words at random, except for one long hold-off
  // at the start of the pressure phase, during which the pipeline fills and
  // the block must stop accepting request words.
  initial begin : result_taker
    int hold_left;
    int seen_phase;
    hold_left = 0;
    seen_phase = -1;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase != seen_phase) begin
        seen_phase = phase;
        if (phase == PRESSURE_PHASE) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Every result word taken at an edge is checked against the oldest
  // prediction. Values read here are those from before the edge.
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      sb.check_result(rsp_ch.left_drive, rsp_ch.right_drive, rsp_ch.steer_mode,
                      rsp_ch.pid_applied, rsp_ch.puck_held);
    end
  end

  // Offers one request word, idling beforehand at the sender's current rate.
  // Valid is only lowered when a gap is actually inserted, so a word that
  // follows straight on keeps valid high without a second assignment.
  task automatic send_word(input logic kind, input logic [LW-1:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.sample <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_input(kind, value);
  endtask

  // Seven samples, one per channel in order, then a steer tick.
  task automatic send_frame(input logic [7*LW-1:0] frame,
                            input logic [LW-1:0] tick_field);
    for (int k = 0; k < psp_pkg::NUM_CH; k++) send_word(REQ_SAMPLE, frame[k*LW +: LW]);
    send_word(REQ_TICK, tick_field);
  endtask

  task automatic cfg_send(input logic [psp_pkg::CFG_IDX_W-1:0] idx,
                          input logic [psp_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  // Writes a whole register set back to back. The narrow registers get
  // random upper bits, which the block has to drop.
  task automatic write_setting(input psp_pkg::cfg_t c, input bit with_spare);
    logic [psp_pkg::CFG_DATA_W-LW-1:0] junk_a;
    logic [psp_pkg::CFG_DATA_W-LW-1:0] junk_b;
    junk_a = (psp_pkg::CFG_DATA_W-LW)'($urandom);
    junk_b = (psp_pkg::CFG_DATA_W-LW)'($urandom);
    cfg_send(psp_pkg::REG_KP_GAIN, c.kp_gain);
    cfg_send(psp_pkg::REG_KI_GAIN, c.ki_gain);
    cfg_send(psp_pkg::REG_KD_GAIN, c.kd_gain);
    cfg_send(psp_pkg::REG_MAX_SPEED, c.max_speed);
    cfg_send(psp_pkg::REG_MIN_SPEED, c.min_speed);
    cfg_send(psp_pkg::REG_TURN_MARGIN, {junk_a, c.turn_margin});
    cfg_send(psp_pkg::REG_PUCK_THRESHOLD, {junk_b, c.puck_threshold});
    if (with_spare) cfg_send(REG_SPARE, psp_pkg::CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic psp_pkg::cfg_t make_setting(
      input logic [psp_pkg::GAIN_W-1:0]  kp,
      input logic [psp_pkg::GAIN_W-1:0]  ki,
      input logic [psp_pkg::GAIN_W-1:0]  kd,
      input logic [psp_pkg::DRIVE_W-1:0] top,
      input logic [psp_pkg::DRIVE_W-1:0] floor_lvl,
      input logic [LW-1:0]               margin,
      input logic [LW-1:0]               thresh);
    psp_pkg::cfg_t c;
    c.kp_gain = kp;
    c.ki_gain = ki;
    c.kd_gain = kd;
    c.max_speed = top;
    c.min_speed = floor_lvl;
    c.turn_margin = margin;
    c.puck_threshold = thresh;
    return c;
  endfunction

  // Stops offering words and waits for every outstanding result word, then
  // lets the pipeline settle so that a trailing sample word has landed.
  task automatic drain_results();
    int waited;
    waited = 0;
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed traffic: a burst of samples around a common level,
  // with a chosen spread so that straight runs, forced turns and the
  // inner/outer disagreement that triggers PID all occur, then a tick.
  // One choice in ten is a lone word of random kind and content.
  task automatic run_random(input int n_items);
    int sent;
    int burst;
    int base;
    int spread;
    int level;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(1'($urandom_range(0, 1)), LW'($urandom_range(0, 1023)));
        sent++;
      end else begin
        burst = int'($urandom_range(0, 9));
        base = int'($urandom_range(0, 1023));
        case ($urandom_range(0, 3))
          0: spread = 4;
          1: spread = 40;
          2: spread = 200;
          default: spread = 1023;
        endcase
        for (int k = 0; k < burst; k++) begin
          level = base + int'($urandom_range(0, 2 * spread)) - spread;
          if (level < 0) level = 0;
          if (level > 1023) level = 1023;
          send_word(REQ_SAMPLE, LW'(level));
        end
        send_word(REQ_TICK, LW'($urandom_range(0, 1023)));
        sent += burst + 1;
      end
    end
  endtask

  initial begin : stimulus
    psp_pkg::cfg_t settings [NUM_PHASES];
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_SAMPLE;
    req_ch.sample <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= psp_pkg::REG_KP_GAIN;
    cfg_ch.data <= '0;
    phase = -1;
    tx_idle_pct = 27;
    rx_idle_pct = 82;

    // A moderate tuning, both extremes of every register, a random set,
    // a set whose full speed lies below its floor, and a narrow band.
    settings[0] = make_setting(16'd26, 16'd3, 16'd40, 16'd255, 16'd50, 10'd50, 10'd300);
    settings[1] = make_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000,
                               10'd0, 10'd0);
    settings[2] = make_setting(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF,
                               10'd1023, 10'd1023);
    settings[3] = make_setting(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom),
                               LW'($urandom_range(0, 1023)), LW'($urandom_range(0, 1023)));
    settings[4] = make_setting(-16'd300, 16'd5, -16'd64, 16'd10, 16'd200, 10'd8, 10'd512);
    settings[5] = make_setting(16'd256, 16'hFFFF, 16'd1, 16'd1000, 16'd999, 10'd300, 10'd1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset register values. The first tick sees
    // an empty store, and its sample field must be ignored.
    send_word(REQ_TICK, 10'h3FF);
    send_frame(FRAME_WRAP, 10'h000);
    send_frame(FRAME_LEFT_PID, 10'h2AA);
    send_frame(FRAME_RIGHT_PID, 10'h155);
    drain_results();

    // Idling goes sender-light/receiver-heavy, then the reverse, then none.
    for (int p = 0; p < NUM_PHASES; p++) begin
      phase = p;
      if (p < 2) begin
        tx_idle_pct = 27;
        rx_idle_pct = 82;
      end else if (p < 4) begin
        tx_idle_pct = 82;
        rx_idle_pct = 27;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_setting(settings[p], p == NUM_PHASES - 1);
      run_random(RANDOM_ITEMS / NUM_PHASES);
      drain_results();
    end

    sb.check_drained();
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
